FILE: rtl/pwbt_pkg.sv
// ----------------------------------------------------------------------------
// pwbt_pkg
// Shared types and constants for the pulse-width byte transmitter.
// ----------------------------------------------------------------------------
package pwbt_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int TICK_W    = 16;
    localparam int BYTE_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT     = 2'd2;

    localparam logic [TICK_W-1:0] RST_START_LOW = 16'd5000;
    localparam logic [TICK_W-1:0] RST_LONG      = 16'd600;
    localparam logic [TICK_W-1:0] RST_SHORT     = 16'd200;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SEND = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] start_low;
        logic [TICK_W-1:0] long_len;
        logic [TICK_W-1:0] short_len;
    } t_cfg;

    typedef struct packed {
        logic rejected;
        logic done_res;
        logic busy_res;
        logic line_level;
    } t_result;

endpackage

FILE: rtl/pwbt_cfg.sv
// ----------------------------------------------------------------------------
// pwbt_cfg
// Timing register file: start, long and short period lengths in ticks.
// ----------------------------------------------------------------------------
module pwbt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pwbt_pkg::TICK_W-1:0]    i_cfg_data,
    output pwbt_pkg::t_cfg                o_cfg
);
    import pwbt_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low <= RST_START_LOW;
            r_cfg.long_len  <= RST_LONG;
            r_cfg.short_len <= RST_SHORT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_LOW: r_cfg.start_low <= i_cfg_data;
                CFG_LONG:      r_cfg.long_len  <= i_cfg_data;
                CFG_SHORT:     r_cfg.short_len <= i_cfg_data;
                default:       ;
            endcase
        end
    end

endmodule

FILE: rtl/pwbt_core.sv
// ----------------------------------------------------------------------------
// pwbt_core
// Frame sequencer: start period, then one high/low bit cell per bit, LSB first.
// ----------------------------------------------------------------------------
module pwbt_core #(
    parameter int FRAME_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_action,
    input  logic [pwbt_pkg::BYTE_W-1:0] i_byte,
    input  pwbt_pkg::t_cfg              i_cfg,
    output pwbt_pkg::t_result           o_res
);
    import pwbt_pkg::*;

    localparam int BL_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam logic [BL_W-1:0] BITS_INIT = BL_W'(FRAME_BITS - 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_ticks, n_ticks;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [BL_W-1:0]     r_bits,  n_bits;
    logic                r_line,  n_line;
    logic                n_done, n_rej;

    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_line  = r_line;
        n_done  = 1'b0;
        n_rej   = 1'b0;
        if (i_action == ACT_SEND) begin
            if (r_phase == PH_IDLE) begin
                n_shift = i_byte;
                n_bits  = BITS_INIT;
                n_ticks = i_cfg.start_low;
                n_line  = 1'b0;
                n_phase = PH_START;
            end else begin
                n_rej = 1'b1;
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_ticks > TICK_W'(1)) begin
                n_ticks = r_ticks - TICK_W'(1);
            end else begin
                case (r_phase)
                    PH_START: begin
                        n_phase = PH_HIGH;
                        n_line  = 1'b1;
                        n_ticks = r_shift[0] ? i_cfg.long_len : i_cfg.short_len;
                    end
                    PH_HIGH: begin
                        n_phase = PH_LOW;
                        n_line  = 1'b0;
                        n_ticks = r_shift[0] ? i_cfg.short_len : i_cfg.long_len;
                    end
                    PH_LOW: begin
                        if (r_bits == '0) begin
                            n_phase = PH_IDLE;
                            n_line  = 1'b1;
                            n_ticks = '0;
                            n_done  = 1'b1;
                        end else begin
                            n_shift = r_shift >> 1;
                            n_bits  = r_bits - BL_W'(1);
                            n_phase = PH_HIGH;
                            n_line  = 1'b1;
                            // next bit is the current bit 1
                            n_ticks = r_shift[1] ? i_cfg.long_len : i_cfg.short_len;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
            r_shift <= '0;
            r_bits  <= '0;
            r_line  <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_line  <= n_line;
        end
    end

    assign o_res.line_level = n_line;
    assign o_res.busy_res   = (n_phase != PH_IDLE);
    assign o_res.done_res   = n_done;
    assign o_res.rejected   = n_rej;

endmodule

FILE: rtl/pwbt_obuf.sv
// ----------------------------------------------------------------------------
// pwbt_obuf
// Result register on the master side; stalls the slave side while a word waits.
// ----------------------------------------------------------------------------
module pwbt_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pwbt_pkg::t_result i_res,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output pwbt_pkg::t_result o_res
);
    import pwbt_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_room  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: rtl/pulse_width_byte_transmitter.sv
// ----------------------------------------------------------------------------
// pulse_width_byte_transmitter
// Single-wire pulse-width command transmitter driven by tick and send words.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tuser=action, tdata=byte
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata=line,busy,done,rejected
//   cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One input word per ready clock; its result word is registered and shows
// the cycle after acceptance. The sequencer state and result register update
// in the same cycle. s_axis_tready drops only while a result word is held by
// m_axis_tready low. Synchronous active-low reset; cfg is always ready.
// ----------------------------------------------------------------------------
module pulse_width_byte_transmitter #(
    parameter int FRAME_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] command_byte
    input  logic                          s_axis_tuser,  // [0] action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] line_level, [1] busy_res, [2] done_res, [3] rejected, [7:4] zero
    output logic [7:0]                    m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pwbt_pkg::TICK_W-1:0]    i_cfg_data
);
    import pwbt_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    t_result w_out;
    logic    w_room;
    logic    w_step;

    assign s_axis_tready = w_room;
    assign w_step        = s_axis_tvalid && w_room;

    pwbt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pwbt_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_action (s_axis_tuser),
        .i_byte   (s_axis_tdata),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    pwbt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out)
    );

    assign m_axis_tdata = {4'b0000, w_out};

endmodule
